// ===== rtl/core/pktdf_pkg.sv =====
// ----------------------------------------------------------------------------
// pktdf_pkg
// Shared constants and codes for the framed packet receiver with two
// alternating body buffers.
// ----------------------------------------------------------------------------
package pktdf_pkg;

	// Largest body a frame may carry, in bytes.
	localparam int BODY_DEPTH = 64;

	// Widths that follow from the body depth.
	localparam int IDX_W  = 6;                  // body byte index
	localparam int LEN_W  = 7;                  // body length, 0 .. BODY_DEPTH
	localparam int ADDR_W = IDX_W + 1;          // buffer select plus index
	localparam int MEM_DEPTH = 2 * BODY_DEPTH;  // two body buffers

	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int EVT_W  = 3;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_MARKER  = 2'd1;

	localparam logic [BYTE_W-1:0] START_RESET = 8'h02;
	localparam logic [BYTE_W-1:0] STOP_RESET  = 8'h03;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

	// Result event codes.
	typedef enum logic [EVT_W-1:0] {
		EV_NONE    = 3'd0,
		EV_ACCEPT  = 3'd1,
		EV_DROP    = 3'd2,
		EV_BADSIZE = 3'd3,
		EV_BADSTOP = 3'd4,
		EV_BADCHK  = 3'd5
	} event_t;

endpackage

// ===== rtl/core/packet_deframer_double_buffer.sv =====
// ----------------------------------------------------------------------------
// packet_deframer_double_buffer
// Framed serial packet receiver with XOR checksum and two body buffers.
// ----------------------------------------------------------------------------
// The block returns exactly one result item for each item it takes, in the
// cycle after acceptance; it sustains one item per clock as long as
// results are taken. An item is a received line byte, a read of a body byte of
// the ready frame, or a release of the ready frame. Line bytes are parsed as
// START, SIZE, TYPE, BODY, STOP, CHECKSUM, where CHECKSUM is the XOR of every
// byte before it. Body bytes are written into the active half of a 128-byte
// body memory; a frame that passes every check is published as ready and the
// other half becomes the write target. A frame that completes while a ready
// frame is still unreleased is discarded and sets the sticky dropped flag. The
// registered read port of the body memory returns read data together with
// the result item. Since writes always go to the active half and reads to the
// ready half, the two ports never touch the same entry in one cycle. The start
// and stop marker registers are written through the configuration port, which
// is always ready; the user must write them only while the block is idle, as
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module packet_deframer_double_buffer
(
	input  logic                              clk,
	input  logic                              arst_n,

	// Item input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pktdf_pkg::KIND_W-1:0]      kind,
	input  logic [pktdf_pkg::BYTE_W-1:0]      rx_byte,
	input  logic [pktdf_pkg::IDX_W-1:0]       read_index,

	// Result output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pktdf_pkg::EVT_W-1:0]       event_res,
	output logic                              msg_ready,
	output logic [pktdf_pkg::LEN_W-1:0]       ready_length,
	output logic [pktdf_pkg::BYTE_W-1:0]      ready_type,
	output logic [pktdf_pkg::BYTE_W-1:0]      read_data,
	output logic                              dropped_sticky,

	// Configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pktdf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pktdf_pkg::BYTE_W-1:0]      cfg_data
);

	import pktdf_pkg::*;

	typedef enum logic [2:0] {
		PH_START,
		PH_SIZE,
		PH_TYPE,
		PH_BODY,
		PH_STOP,
		PH_CHK
	} phase_t;

	// Parser and buffer state.
	phase_t              phase_q, phase_d;
	logic [LEN_W-1:0]    exp_len_q, exp_len_d;
	logic [LEN_W-1:0]    pos_q, pos_d;
	logic [BYTE_W-1:0]   xor_q, xor_d;
	logic [BYTE_W-1:0]   type_q, type_d;
	logic [LEN_W-1:0]    rdy_len_q, rdy_len_d;
	logic [BYTE_W-1:0]   rdy_type_q, rdy_type_d;
	logic                active_q, active_d;
	logic                ready_q, ready_d;
	logic                dropped_q, dropped_d;
	logic [BYTE_W-1:0]   start_q;
	logic [BYTE_W-1:0]   stop_q;

	// Result stage.
	logic                valid_s1;
	event_t              event_s1;
	logic                hit_s1;
	event_t              ev_d;
	logic                hit_d;

	// Body memory.
	logic [BYTE_W-1:0]   body_mem [MEM_DEPTH];
	logic [BYTE_W-1:0]   rd_data_q;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   rd_addr;
	logic [LEN_W-1:0]    pos_inc;
	logic                accept;

	// A new item is taken whenever the result register is empty or is being
	// drained in the same cycle.
	assign in_stall  = valid_s1 && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign pos_inc = pos_q + LEN_W'(1);
	assign wr_addr = {active_q, pos_q[IDX_W-1:0]};
	assign rd_addr = {~active_q, read_index};

	// Next-state logic for one item.
	always_comb begin
		phase_d    = phase_q;
		exp_len_d  = exp_len_q;
		pos_d      = pos_q;
		xor_d      = xor_q;
		type_d     = type_q;
		rdy_len_d  = rdy_len_q;
		rdy_type_d = rdy_type_q;
		active_d   = active_q;
		ready_d    = ready_q;
		dropped_d  = dropped_q;
		ev_d       = EV_NONE;
		hit_d      = 1'b0;
		wr_en      = 1'b0;
		case (kind)
			KIND_BYTE: begin
				case (phase_q)
					PH_START: begin
						if (rx_byte == start_q) begin
							xor_d     = start_q;
							pos_d     = '0;
							exp_len_d = '0;
							phase_d   = PH_SIZE;
						end
					end
					PH_SIZE: begin
						if (rx_byte == '0 || rx_byte > BYTE_W'(BODY_DEPTH)) begin
							ev_d    = EV_BADSIZE;
							phase_d = PH_START;
						end else begin
							exp_len_d = rx_byte[LEN_W-1:0];
							xor_d     = xor_q ^ rx_byte;
							phase_d   = PH_TYPE;
						end
					end
					PH_TYPE: begin
						type_d  = rx_byte;
						xor_d   = xor_q ^ rx_byte;
						phase_d = PH_BODY;
					end
					PH_BODY: begin
						wr_en = 1'b1;
						pos_d = pos_inc;
						xor_d = xor_q ^ rx_byte;
						if (pos_inc >= exp_len_q) begin
							phase_d = PH_STOP;
						end
					end
					PH_STOP: begin
						if (rx_byte == stop_q) begin
							xor_d   = xor_q ^ stop_q;
							phase_d = PH_CHK;
						end else begin
							ev_d    = EV_BADSTOP;
							phase_d = PH_START;
						end
					end
					PH_CHK: begin
						if (rx_byte == xor_q) begin
							if (ready_q) begin
								dropped_d = 1'b1;
								ev_d      = EV_DROP;
							end else begin
								rdy_len_d  = exp_len_q;
								rdy_type_d = type_q;
								ready_d    = 1'b1;
								active_d   = ~active_q;
								ev_d       = EV_ACCEPT;
							end
						end else begin
							ev_d = EV_BADCHK;
						end
						phase_d = PH_START;
					end
					default: begin
						phase_d = PH_START;
					end
				endcase
			end
			KIND_READ: begin
				hit_d = ready_q && ({1'b0, read_index} < rdy_len_q);
			end
			KIND_RELEASE: begin
				ready_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// State, configuration and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			exp_len_q  <= '0;
			pos_q      <= '0;
			xor_q      <= '0;
			type_q     <= '0;
			rdy_len_q  <= '0;
			rdy_type_q <= '0;
			active_q   <= 1'b0;
			ready_q    <= 1'b0;
			dropped_q  <= 1'b0;
			start_q    <= START_RESET;
			stop_q     <= STOP_RESET;
			valid_s1   <= 1'b0;
			event_s1   <= EV_NONE;
			hit_s1     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_START_MARKER) begin
					start_q <= cfg_data;
				end
				if (cfg_index == CFG_STOP_MARKER) begin
					stop_q <= cfg_data;
				end
			end
			if (accept) begin
				phase_q    <= phase_d;
				exp_len_q  <= exp_len_d;
				pos_q      <= pos_d;
				xor_q      <= xor_d;
				type_q     <= type_d;
				rdy_len_q  <= rdy_len_d;
				rdy_type_q <= rdy_type_d;
				active_q   <= active_d;
				ready_q    <= ready_d;
				dropped_q  <= dropped_d;
				event_s1   <= ev_d;
				hit_s1     <= hit_d;
				valid_s1   <= 1'b1;
			end else if (!out_stall) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Body memory: one write port for line bytes, one registered read port
	// for the consumer. The read register only moves when an item is taken,
	// so it holds while the result is stalled.
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			body_mem[wr_addr] <= rx_byte;
		end
		if (accept && kind == KIND_READ) begin
			rd_data_q <= body_mem[rd_addr];
		end
	end

	// Status fields come straight from state, which does not move while a
	// result waits.
	assign out_valid      = valid_s1;
	assign event_res      = event_s1;
	assign msg_ready      = ready_q;
	assign ready_length   = ready_q ? rdy_len_q : '0;
	assign ready_type     = ready_q ? rdy_type_q : '0;
	assign read_data      = hit_s1 ? rd_data_q : '0;
	assign dropped_sticky = dropped_q;

	// An accepted frame is always reported as ready.
	a_accept_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == EV_ACCEPT) |-> msg_ready)
		else $error("accepted frame not marked ready");

	// The dropped flag never clears once set.
	a_dropped_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |=> dropped_q)
		else $error("dropped flag cleared");

	// Publishing a frame swaps the write buffer.
	a_swap_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ev_d == EV_ACCEPT) |=> (active_q != $past(active_q)))
		else $error("write buffer not swapped on accept");

	// Body bytes are only returned from a ready frame.
	a_read_needs_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && read_data != '0) |-> msg_ready)
		else $error("body data returned without a ready frame");

	// A bad frame always sends the parser back to hunting.
	a_error_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (ev_d == EV_BADSIZE || ev_d == EV_BADSTOP || ev_d == EV_BADCHK))
		|=> (phase_q == PH_START))
		else $error("parser did not return to hunting after an error");

endmodule

// ===== dv/packet_deframer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_deframer_checker
// Watches the item, result and configuration channels of the packet
// deframer, predicts the status that each accepted item must produce and
// compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module packet_deframer_checker
(
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [pktdf_pkg::KIND_W-1:0]      kind,
	input  logic [pktdf_pkg::BYTE_W-1:0]      rx_byte,
	input  logic [pktdf_pkg::IDX_W-1:0]       read_index,

	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [pktdf_pkg::EVT_W-1:0]       event_res,
	input  logic                              msg_ready,
	input  logic [pktdf_pkg::LEN_W-1:0]       ready_length,
	input  logic [pktdf_pkg::BYTE_W-1:0]      ready_type,
	input  logic [pktdf_pkg::BYTE_W-1:0]      read_data,
	input  logic                              dropped_sticky,

	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [pktdf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pktdf_pkg::BYTE_W-1:0]      cfg_data,

	output int                                fail_count,
	output int                                status_owed,
	output int                                status_checked,
	output int                                frames_accepted,
	output int                                frames_dropped,
	output int                                frames_rejected
);

	import pktdf_pkg::*;

	typedef enum logic [2:0] {
		HUNT,
		GET_SIZE,
		GET_TYPE,
		GET_BODY,
		GET_STOP,
		GET_CHECK
	} parse_phase_t;

	typedef struct packed {
		event_t              evt;
		logic                ready;
		logic [LEN_W-1:0]    length;
		logic [BYTE_W-1:0]   ftype;
		logic [BYTE_W-1:0]   data;
		logic                dropped;
	} status_t;

	// Predicted copy of the receiver.
	logic [BYTE_W-1:0] start_mk, stop_mk;
	parse_phase_t      phase;
	logic [LEN_W-1:0]  want_len, body_pos;
	logic [BYTE_W-1:0] xor_acc, cur_type;
	logic [BYTE_W-1:0] body_mem [MEM_DEPTH];
	logic [LEN_W-1:0]  buf_len [2];
	logic [BYTE_W-1:0] buf_type [2];
	logic              wr_buf, have_ready, lost_frame;

	status_t status_due [$];
	int      mismatches, checked, n_accept, n_drop, n_reject;

	function automatic status_t advance_deframer(input logic [KIND_W-1:0] k,
			input logic [BYTE_W-1:0] b, input logic [IDX_W-1:0] idx);
		status_t s;
		logic    rd_buf;
		s = '0;
		s.evt = EV_NONE;
		rd_buf = ~wr_buf;
		if (k == KIND_BYTE) begin
			case (phase)
				HUNT: begin
					if (b == start_mk) begin
						xor_acc = start_mk;
						body_pos = '0;
						want_len = '0;
						phase = GET_SIZE;
					end
				end
				GET_SIZE: begin
					if (b == '0 || b > BODY_DEPTH) begin
						s.evt = EV_BADSIZE;
						phase = HUNT;
					end else begin
						want_len = LEN_W'(b);
						xor_acc ^= b;
						phase = GET_TYPE;
					end
				end
				GET_TYPE: begin
					cur_type = b;
					xor_acc ^= b;
					phase = GET_BODY;
				end
				GET_BODY: begin
					if (body_pos < BODY_DEPTH)
						body_mem[{wr_buf, body_pos[IDX_W-1:0]}] = b;
					body_pos++;
					xor_acc ^= b;
					if (body_pos >= want_len)
						phase = GET_STOP;
				end
				GET_STOP: begin
					if (b == stop_mk) begin
						xor_acc ^= stop_mk;
						phase = GET_CHECK;
					end else begin
						s.evt = EV_BADSTOP;
						phase = HUNT;
					end
				end
				GET_CHECK: begin
					if (b == xor_acc) begin
						if (have_ready) begin
							lost_frame = 1'b1;
							s.evt = EV_DROP;
						end else begin
							buf_len[wr_buf] = want_len;
							buf_type[wr_buf] = cur_type;
							buf_len[~wr_buf] = '0;
							have_ready = 1'b1;
							wr_buf = ~wr_buf;
							s.evt = EV_ACCEPT;
						end
					end else begin
						s.evt = EV_BADCHK;
					end
					phase = HUNT;
				end
				default: phase = HUNT;
			endcase
		end else if (k == KIND_READ) begin
			if (have_ready && LEN_W'(idx) < buf_len[rd_buf])
				s.data = body_mem[{rd_buf, idx}];
		end else if (k == KIND_RELEASE) begin
			have_ready = 1'b0;
		end
		// A freshly accepted frame flips the buffers, so look again.
		rd_buf = ~wr_buf;
		if (have_ready) begin
			s.length = buf_len[rd_buf];
			s.ftype = buf_type[rd_buf];
		end
		s.ready = have_ready;
		s.dropped = lost_frame;
		return s;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		status_t want;
		if (!arst_n) begin
			start_mk = START_RESET;
			stop_mk = STOP_RESET;
			phase = HUNT;
			want_len = '0;
			body_pos = '0;
			xor_acc = '0;
			cur_type = '0;
			buf_len[0] = '0;
			buf_len[1] = '0;
			buf_type[0] = '0;
			buf_type[1] = '0;
			wr_buf = 1'b0;
			have_ready = 1'b0;
			lost_frame = 1'b0;
			status_due.delete();
			mismatches = 0;
			checked = 0;
			n_accept = 0;
			n_drop = 0;
			n_reject = 0;
			fail_count <= 0;
			status_owed <= 0;
			status_checked <= 0;
			frames_accepted <= 0;
			frames_dropped <= 0;
			frames_rejected <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_MARKER: start_mk = cfg_data;
					CFG_STOP_MARKER:  stop_mk = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					$error("result item arrived with no item outstanding");
					mismatches++;
				end else begin
					want = status_due.pop_front();
					checked++;
					case (want.evt)
						EV_ACCEPT: n_accept++;
						EV_DROP:   n_drop++;
						EV_BADSIZE, EV_BADSTOP, EV_BADCHK: n_reject++;
						default: ;
					endcase
					check_field("event_res", 32'(want.evt), 32'(event_res));
					check_field("msg_ready", 32'(want.ready), 32'(msg_ready));
					check_field("ready_length", 32'(want.length), 32'(ready_length));
					check_field("ready_type", 32'(want.ftype), 32'(ready_type));
					check_field("read_data", 32'(want.data), 32'(read_data));
					check_field("dropped_sticky", 32'(want.dropped), 32'(dropped_sticky));
				end
			end
			if (in_valid && !in_stall)
				status_due.push_back(advance_deframer(kind, rx_byte, read_index));
			fail_count <= mismatches;
			status_owed <= status_due.size();
			status_checked <= checked;
			frames_accepted <= n_accept;
			frames_dropped <= n_drop;
			frames_rejected <= n_reject;
		end
	end

endmodule

// ===== dv/tb_packet_deframer_double_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packet_deframer_double_buffer
// Drives framed line bytes, body reads and buffer releases into the packet
// deframer under several start and stop marker settings, with bursty input
// and a stalling receiver; a checker beside the block predicts and compares
// every result item.
// ----------------------------------------------------------------------------
module tb_packet_deframer_double_buffer;
	import pktdf_pkg::*;

	// Ways a generated frame can be broken.
	localparam int FAULT_NONE = 0;
	localparam int FAULT_SIZE = 1;
	localparam int FAULT_STOP = 2;
	localparam int FAULT_CHK  = 3;

	// The one kind value the block has no use for.
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// Length of the receiver hold-off that forces the block to back up.
	localparam int HOLD_CYCLES = 80;
	// Cycles without any accepted item before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n;

	logic                 in_valid;
	logic                 in_stall;
	logic [KIND_W-1:0]    kind;
	logic [BYTE_W-1:0]    rx_byte;
	logic [IDX_W-1:0]     read_index;

	logic                 out_valid;
	logic                 out_stall;
	logic [EVT_W-1:0]     event_res;
	logic                 msg_ready;
	logic [LEN_W-1:0]     ready_length;
	logic [BYTE_W-1:0]    ready_type;
	logic [BYTE_W-1:0]    read_data;
	logic                 dropped_sticky;

	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;

	int fail_count, status_owed, status_checked;
	int frames_accepted, frames_dropped, frames_rejected;

	// Stimulus bookkeeping. The marker copies let the frame builder use the
	// values that are currently programmed into the block.
	logic [BYTE_W-1:0] start_mk, stop_mk;
	int burst_left;
	int items_sent;
	int settings_run;
	int hold_requests;

	packet_deframer_double_buffer u_dut (.*);

	packet_deframer_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one item and wait until the block takes it. The sender works in
	// bursts: when a burst runs out, valid drops for a random gap (sometimes
	// none, which strings bursts together) and a new burst length is drawn.
	// Valid is only lowered when a gap really follows, so it never gets two
	// assignments in one time step.
	task automatic drive_item(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
			input logic [IDX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		kind <= k;
		rx_byte <= b;
		read_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		// Items of the unused kind are only noise and do not count.
		if (k != KIND_UNUSED)
			items_sent++;
	endtask

	// A line byte; the read index is a don't-care and gets random bits.
	task automatic put_byte(input logic [BYTE_W-1:0] b);
		drive_item(KIND_BYTE, b, IDX_W'($urandom));
	endtask

	// Send one frame under the current markers. The checksum is the XOR of
	// every byte before it, start and stop included. A broken frame stops at
	// the byte that breaks it, since the block goes back to hunting there.
	task automatic send_frame(input int len, input logic [BYTE_W-1:0] ftype,
			input int fault, input bit marker_in_body);
		logic [BYTE_W-1:0] sum, b, sz;
		sum = start_mk;
		put_byte(start_mk);
		if (fault == FAULT_SIZE) begin
			sz = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(BODY_DEPTH + 1, 255));
			put_byte(sz);
			return;
		end
		put_byte(8'(len));
		sum ^= 8'(len);
		put_byte(ftype);
		sum ^= ftype;
		for (int i = 0; i < len; i++) begin
			// A start marker inside the body must be taken as plain data.
			if ((marker_in_body && i == 0) || $urandom_range(0, 7) == 0)
				b = start_mk;
			else
				b = 8'($urandom);
			put_byte(b);
			sum ^= b;
		end
		if (fault == FAULT_STOP) begin
			put_byte(stop_mk ^ 8'($urandom_range(1, 255)));
			return;
		end
		put_byte(stop_mk);
		sum ^= stop_mk;
		if (fault == FAULT_CHK)
			sum ^= 8'($urandom_range(1, 255));
		put_byte(sum);
	endtask

	// Drop valid and wait until every result item has come back. Each item
	// yields exactly one result, so the block is idle once nothing is owed;
	// a further wait covers the output register.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_owed != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Program both markers back to back; valid stays high between the two.
	task automatic write_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] p);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_START_MARKER;
		cfg_data <= s;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_STOP_MARKER;
		cfg_data <= p;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		start_mk = s;
		stop_mk = p;
		settings_run++;
	endtask

	// Random traffic: half of the picks are well-formed frames with random content,
	// so the parser gets all the way to the checksum; the rest are body reads,
	// releases, broken frames, stray bytes and unused kinds.
	task automatic run_random(input int n);
		int target, r, len, pick;
		target = items_sent + n;
		while (items_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				pick = $urandom_range(0, 99);
				if (pick < 5)
					len = BODY_DEPTH;
				else if (pick < 15)
					len = $urandom_range(7, BODY_DEPTH - 1);
				else
					len = $urandom_range(1, 6);
				send_frame(len, 8'($urandom), FAULT_NONE, 1'b0);
			end else if (r < 60) begin
				send_frame($urandom_range(1, 6), 8'($urandom),
					$urandom_range(FAULT_SIZE, FAULT_CHK), 1'b0);
			end else if (r < 75) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1))
						drive_item(KIND_READ, 8'($urandom), IDX_W'($urandom_range(0, 7)));
					else
						drive_item(KIND_READ, 8'($urandom), IDX_W'($urandom));
				end
			end else if (r < 88) begin
				drive_item(KIND_RELEASE, 8'($urandom), IDX_W'($urandom));
			end else if (r < 95) begin
				put_byte(8'($urandom));
			end else begin
				drive_item(KIND_UNUSED, 8'($urandom), IDX_W'($urandom));
			end
		end
	endtask

	// Receiver: its stall pattern switches between free running, light and
	// heavy stalling for random stretches. When the stimulus asks for it, it
	// holds off completely for a long count of cycles so that the block fills
	// up and has to stall its input while the sender keeps offering items.
	initial begin
		int mode, mode_left, served;
		out_stall = 1'b0;
		mode = 0;
		mode_left = 0;
		served = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				served = hold_requests;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	// Watchdog: any accepted item on any channel restarts the count.
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("packet_deframer_double_buffer verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_BYTE;
		rx_byte = '0;
		read_index = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_START_MARKER;
		cfg_data = '0;
		start_mk = START_RESET;
		stop_mk = STOP_RESET;
		burst_left = 0;
		items_sent = 0;
		settings_run = 1;
		hold_requests = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the markers at their reset values. A stray byte
		// while hunting and an unused kind must leave everything alone, as
		// must a read and a release with no frame ready.
		put_byte(8'h55);
		drive_item(KIND_UNUSED, 8'hAA, 6'h2A);
		drive_item(KIND_READ, 8'h00, 6'd0);
		drive_item(KIND_RELEASE, 8'hFF, 6'h3F);
		// Sizes of zero and of the largest byte value are both rejected.
		put_byte(start_mk);
		put_byte(8'h00);
		put_byte(start_mk);
		put_byte(8'hFF);
		// A one-byte frame whose body is the start marker, then reads inside
		// and beyond its length.
		send_frame(1, 8'hFF, FAULT_NONE, 1'b1);
		drive_item(KIND_READ, 8'h00, 6'd0);
		drive_item(KIND_READ, 8'hFF, 6'h3F);
		// A wrong stop byte and a wrong checksum while a frame is ready.
		send_frame(1, 8'h00, FAULT_STOP, 1'b0);
		send_frame(1, 8'h00, FAULT_CHK, 1'b0);
		drive_item(KIND_RELEASE, 8'h00, 6'd0);

		// Random part, over several marker settings including the extremes
		// and equal start and stop values. Two phases open with a long
		// receiver hold-off.
		hold_requests <= hold_requests + 1;
		run_random(260);
		wait_idle();
		write_markers(8'h00, 8'hFF);
		run_random(160);
		wait_idle();
		write_markers(8'hFF, 8'h00);
		hold_requests <= hold_requests + 1;
		run_random(160);
		wait_idle();
		write_markers(8'h5A, 8'h5A);
		run_random(160);
		wait_idle();
		write_markers(8'($urandom), 8'($urandom));
		run_random(160);

		// Drain: everything owed must arrive, then a further wait for anything
		// the block might still put out on its own.
		wait_idle();
		repeat (4) @(posedge clk);

		$display("Run summary: %0d items under %0d marker settings, %0d results compared.",
			items_sent, settings_run, status_checked);
		$display("Frames seen: %0d accepted, %0d dropped, %0d rejected for size, stop or checksum.",
			frames_accepted, frames_dropped, frames_rejected);
		if (fail_count == 0) begin
			$display("packet_deframer_double_buffer verification clean");
		end else begin
			$display("packet_deframer_double_buffer verification failed");
		end
		$finish;
	end

endmodule

// ===== packet_deframer_double_buffer.f =====
rtl/core/pktdf_pkg.sv
rtl/core/packet_deframer_double_buffer.sv
dv/packet_deframer_checker.sv
dv/tb_packet_deframer_double_buffer.sv
